[rtl/sfbp_pkg.sv]
// shared types and constants of the stomp frame byte parser
package sfbp_pkg;

    localparam int MAX_TOKEN = 1024;
    localparam int TOKEN_W   = $clog2(MAX_TOKEN + 1);

    // parse event codes
    localparam logic [3:0] EV_NONE        = 4'd0;
    localparam logic [3:0] EV_FRAME_START = 4'd1;
    localparam logic [3:0] EV_METHOD_CHAR = 4'd2;
    localparam logic [3:0] EV_METHOD_END  = 4'd3;
    localparam logic [3:0] EV_KEY_CHAR    = 4'd4;
    localparam logic [3:0] EV_KEY_END     = 4'd5;
    localparam logic [3:0] EV_KEY_DROP    = 4'd6;
    localparam logic [3:0] EV_VALUE_CHAR  = 4'd7;
    localparam logic [3:0] EV_VALUE_END   = 4'd8;
    localparam logic [3:0] EV_BODY_BYTE   = 4'd9;
    localparam logic [3:0] EV_FRAME_END   = 4'd10;
    localparam logic [3:0] EV_ERROR       = 4'd11;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_REQ_LINE  = 3'd1;
    localparam logic [2:0] ERR_METHOD    = 3'd2;
    localparam logic [2:0] ERR_FRAME     = 3'd3;
    localparam logic [2:0] ERR_TOKEN_BIG = 3'd4;

    typedef struct packed {
        logic [3:0] event_kind;
        logic [7:0] out_char;
        logic [2:0] error_code;
    } result_t;

endpackage

[rtl/sfbp_if.sv]
// valid/ready channel interfaces for the byte input and the event output
interface sfbp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  in_byte;
    logic [31:0] body_length;

    modport source (output valid, output in_byte, output body_length, input ready);
    modport sink   (input valid, input in_byte, input body_length, output ready);
endinterface

interface sfbp_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_kind;
    logic [7:0] out_char;
    logic [2:0] error_code;

    modport source (output valid, output event_kind, output out_char, output error_code,
                    input ready);
    modport sink   (input valid, input event_kind, input out_char, input error_code,
                    output ready);
endinterface

[rtl/sfbp_step.sv]
// parse state machine: one byte in, one event out, state advanced per accepted beat
module sfbp_step
    import sfbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  in_byte,
    input  logic [31:0] body_length,
    output result_t     res
);

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_METHOD     = 4'd1,
        PH_LINE_CR    = 4'd2,
        PH_LINE_START = 4'd3,
        PH_KEY        = 4'd4,
        PH_VALUE      = 4'd5,
        PH_HDR_CR     = 4'd6,
        PH_HDR_END    = 4'd7,
        PH_BODY_LEN   = 4'd8,
        PH_BODY_NUL   = 4'd9,
        PH_FRAME_END  = 4'd10
    } phase_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    phase_t             phase_reg, phase_next;
    logic               esc_reg, esc_next;
    logic [TOKEN_W-1:0] tok_reg, tok_next;
    logic [31:0]        rem_reg, rem_next;
    logic [2:0]         err_reg, err_next;

    logic [3:0]  kind;
    logic [7:0]  ch;
    logic        is_eol, is_upper, is_key_ch, is_val_ch, tok_full;
    logic        unesc_ok;
    logic [7:0]  unesc_ch;
    logic [31:0] rem_dec;

    always_comb
    begin
        is_eol    = (in_byte == CH_LF) || (in_byte == CH_CR);
        is_upper  = (in_byte >= CH_A) && (in_byte <= CH_Z);
        is_key_ch = (in_byte >= CH_BANG) && (in_byte <= CH_TILDE);
        is_val_ch = (in_byte >= CH_SPACE) && (in_byte <= CH_TILDE);
        tok_full  = tok_reg >= TOKEN_W'(MAX_TOKEN);
        rem_dec   = (rem_reg != 32'd0) ? rem_reg - 32'd1 : rem_reg;
        unesc_ok  = 1'b1;
        case (in_byte)
            CH_N:    unesc_ch = CH_LF;
            CH_R:    unesc_ch = CH_CR;
            CH_C:    unesc_ch = CH_COLON;
            CH_BSL:  unesc_ch = CH_BSL;
            default:
            begin
                unesc_ch = CH_NUL;
                unesc_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        tok_next   = tok_reg;
        rem_next   = rem_reg;
        err_next   = err_reg;
        kind       = EV_NONE;
        ch         = CH_NUL;

        if (err_reg != ERR_NONE)
        begin
            kind = EV_ERROR;
        end
        else
        begin
            case (phase_reg)
                PH_METHOD:
                begin
                    if (is_upper)
                    begin
                        if (tok_full)
                        begin
                            err_next = ERR_TOKEN_BIG;
                            kind     = EV_ERROR;
                        end
                        else
                        begin
                            tok_next = tok_reg + TOKEN_W'(1);
                            kind     = EV_METHOD_CHAR;
                            ch       = in_byte;
                        end
                    end
                    else if (is_eol)
                    begin
                        tok_next   = '0;
                        phase_next = (in_byte == CH_LF) ? PH_LINE_START : PH_LINE_CR;
                        kind       = EV_METHOD_END;
                    end
                    else
                    begin
                        err_next = ERR_METHOD;
                        kind     = EV_ERROR;
                    end
                end
                PH_LINE_CR, PH_HDR_CR:
                begin
                    if (in_byte == CH_LF)
                    begin
                        phase_next = (phase_reg == PH_LINE_CR) ? PH_LINE_START : PH_HDR_END;
                    end
                    else
                    begin
                        err_next = ERR_REQ_LINE;
                        kind     = EV_ERROR;
                    end
                end
                PH_LINE_START:
                begin
                    if (in_byte == CH_CR)
                    begin
                        phase_next = PH_HDR_CR;
                    end
                    else if (in_byte == CH_LF)
                    begin
                        phase_next = PH_HDR_END;
                    end
                    else if (!is_key_ch)
                    begin
                        err_next = ERR_REQ_LINE;
                        kind     = EV_ERROR;
                    end
                    else if (in_byte == CH_BSL)
                    begin
                        phase_next = PH_KEY;
                        esc_next   = 1'b1;
                        tok_next   = '0;
                    end
                    else if (in_byte == CH_COLON)
                    begin
                        // empty key
                        phase_next = PH_VALUE;
                        esc_next   = 1'b0;
                        tok_next   = '0;
                        kind       = EV_KEY_END;
                    end
                    else
                    begin
                        phase_next = PH_KEY;
                        esc_next   = 1'b0;
                        tok_next   = TOKEN_W'(1);
                        kind       = EV_KEY_CHAR;
                        ch         = in_byte;
                    end
                end
                PH_KEY, PH_VALUE:
                begin
                    if (esc_reg)
                    begin
                        if (!unesc_ok)
                        begin
                            err_next = ERR_FRAME;
                            kind     = EV_ERROR;
                        end
                        else if (tok_full)
                        begin
                            err_next = ERR_TOKEN_BIG;
                            kind     = EV_ERROR;
                        end
                        else
                        begin
                            tok_next = tok_reg + TOKEN_W'(1);
                            esc_next = 1'b0;
                            kind     = (phase_reg == PH_KEY) ? EV_KEY_CHAR : EV_VALUE_CHAR;
                            ch       = unesc_ch;
                        end
                    end
                    else if (in_byte == CH_BSL)
                    begin
                        esc_next = 1'b1;
                    end
                    else if (phase_reg == PH_KEY && in_byte == CH_COLON)
                    begin
                        tok_next   = '0;
                        phase_next = PH_VALUE;
                        kind       = EV_KEY_END;
                    end
                    else if (is_eol)
                    begin
                        tok_next   = '0;
                        phase_next = (in_byte == CH_LF) ? PH_LINE_START : PH_LINE_CR;
                        kind       = (phase_reg == PH_KEY) ? EV_KEY_DROP : EV_VALUE_END;
                    end
                    else if ((phase_reg == PH_KEY) ? is_key_ch : is_val_ch)
                    begin
                        if (tok_full)
                        begin
                            err_next = ERR_TOKEN_BIG;
                            kind     = EV_ERROR;
                        end
                        else
                        begin
                            tok_next = tok_reg + TOKEN_W'(1);
                            kind     = (phase_reg == PH_KEY) ? EV_KEY_CHAR : EV_VALUE_CHAR;
                            ch       = in_byte;
                        end
                    end
                    else
                    begin
                        err_next = ERR_FRAME;
                        kind     = EV_ERROR;
                    end
                end
                PH_HDR_END:
                begin
                    // length is sampled on the first byte after the blank line
                    if (body_length != 32'd0)
                    begin
                        rem_next   = body_length - 32'd1;
                        phase_next = (body_length == 32'd1) ? PH_FRAME_END : PH_BODY_LEN;
                        kind       = EV_BODY_BYTE;
                        ch         = in_byte;
                    end
                    else if (in_byte == CH_NUL)
                    begin
                        phase_next = PH_IDLE;
                        kind       = EV_FRAME_END;
                    end
                    else
                    begin
                        phase_next = PH_BODY_NUL;
                        kind       = EV_BODY_BYTE;
                        ch         = in_byte;
                    end
                end
                PH_BODY_LEN:
                begin
                    rem_next = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        phase_next = PH_FRAME_END;
                    end
                    kind = EV_BODY_BYTE;
                    ch   = in_byte;
                end
                PH_BODY_NUL:
                begin
                    if (in_byte == CH_NUL)
                    begin
                        phase_next = PH_IDLE;
                        kind       = EV_FRAME_END;
                    end
                    else
                    begin
                        kind = EV_BODY_BYTE;
                        ch   = in_byte;
                    end
                end
                PH_FRAME_END:
                begin
                    if (in_byte == CH_NUL)
                    begin
                        phase_next = PH_IDLE;
                        kind       = EV_FRAME_END;
                    end
                    else
                    begin
                        err_next = ERR_FRAME;
                        kind     = EV_ERROR;
                    end
                end
                default:
                begin
                    // idle, and any code outside the phase list
                    phase_next = PH_IDLE;
                    if (is_eol || in_byte == CH_NUL)
                    begin
                        kind = EV_NONE;
                    end
                    else if (is_upper)
                    begin
                        tok_next   = TOKEN_W'(1);
                        esc_next   = 1'b0;
                        phase_next = PH_METHOD;
                        kind       = EV_FRAME_START;
                        ch         = in_byte;
                    end
                    else
                    begin
                        err_next = ERR_REQ_LINE;
                        kind     = EV_ERROR;
                    end
                end
            endcase
        end

        res.event_kind = kind;
        res.out_char   = ch;
        res.error_code = (kind == EV_ERROR) ? err_next : ERR_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            esc_reg   <= 1'b0;
            tok_reg   <= '0;
            rem_reg   <= '0;
            err_reg   <= ERR_NONE;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            tok_reg   <= tok_next;
            rem_reg   <= rem_next;
            err_reg   <= err_next;
        end
    end

endmodule

[rtl/sfbp_out_buf.sv]
// result register with a skid stage in front of the event channel
module sfbp_out_buf
    import sfbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  result_t    res,
    output logic       can_take,
    sfbp_out_if.source tx
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop      = main_valid_reg && tx.ready;
    assign can_take = !skid_valid_reg;

    assign tx.valid      = main_valid_reg;
    assign tx.event_kind = main_reg.event_kind;
    assign tx.out_char   = main_reg.out_char;
    assign tx.error_code = main_reg.error_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (take)
        begin
            if (!main_valid_reg || pop)
            begin
                main_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (take)
        begin
            if (!main_valid_reg || pop)
            begin
                main_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
    end

endmodule

[rtl/stomp_frame_byte_parser_core.sv]
// STOMP frame byte parser: one raw byte per beat in, one parse event per beat out,
// with a throughput of one byte per clock while the skid entry of the output buffer is
// empty; the event for an accepted byte is registered into the output buffer, and the
// single parse state machine advances once per accepted byte; a two-entry output buffer
// lets the input keep flowing for one extra beat while the event side stalls.
module stomp_frame_byte_parser_core
    import sfbp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    sfbp_in_if.sink  rx,
    sfbp_out_if.source tx
);

    result_t res;
    logic    can_take;
    logic    take;

    assign rx.ready = can_take;
    assign take     = rx.valid && can_take;

    sfbp_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .in_byte     (rx.in_byte),
        .body_length (rx.body_length),
        .res         (res)
    );

    sfbp_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .res      (res),
        .can_take (can_take),
        .tx       (tx)
    );

endmodule

[rtl/sfbp_checker.sv]
// port-level checks of the parser, bound to the top level
module sfbp_checker
    import sfbp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       tx_valid,
    input logic       tx_ready,
    input logic [3:0] event_kind,
    input logic [7:0] out_char,
    input logic [2:0] error_code
);

    // a stalled event beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid && $stable(event_kind)
            && $stable(out_char) && $stable(error_code))
    else $error("event beat changed while stalled");

    // error code present exactly on error events
    assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid |-> ((event_kind == EV_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not match event kind");

    // once an error is delivered every later event is the same error
    assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_ready && event_kind == EV_ERROR
            |=> !tx_valid || (event_kind == EV_ERROR && error_code == $past(error_code)))
    else $error("error not sticky");

    // events that carry no character show zero
    assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && (event_kind == EV_NONE || event_kind == EV_METHOD_END
            || event_kind == EV_KEY_END || event_kind == EV_KEY_DROP
            || event_kind == EV_VALUE_END || event_kind == EV_FRAME_END
            || event_kind == EV_ERROR) |-> out_char == 8'd0)
    else $error("non-zero character on a control event");

endmodule

bind stomp_frame_byte_parser_core sfbp_checker u_sfbp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tx_valid   (tx.valid),
    .tx_ready   (tx.ready),
    .event_kind (tx.event_kind),
    .out_char   (tx.out_char),
    .error_code (tx.error_code)
);
